### src/gcd_lcm_pkg.sv
// gcd_lcm_pkg: shared constants, control word type and microcode rom for gcd_lcm_unit
// no dependencies
package gcd_lcm_pkg;

  localparam int DATA_WIDTH_DEF = 31;

  // micro program counter
  localparam int PC_W = 3;

  // datapath operations
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_GSTEP = 3'd1;
  localparam logic [2:0] OP_GFIN  = 3'd2;
  localparam logic [2:0] OP_DSTEP = 3'd3;
  localparam logic [2:0] OP_MINIT = 3'd4;
  localparam logic [2:0] OP_MSTEP = 3'd5;
  localparam logic [2:0] OP_DONE  = 3'd6;

  // sequencer conditions
  localparam logic [1:0] COND_NEXT = 2'd0;
  localparam logic [1:0] COND_LIVE = 2'd1;
  localparam logic [1:0] COND_CNT  = 2'd2;
  localparam logic [1:0] COND_ZERO = 2'd3;

  // program addresses
  localparam logic [PC_W-1:0] PC_GCD  = 3'd0;
  localparam logic [PC_W-1:0] PC_GFIN = 3'd1;
  localparam logic [PC_W-1:0] PC_DIV  = 3'd2;
  localparam logic [PC_W-1:0] PC_MINI = 3'd3;
  localparam logic [PC_W-1:0] PC_MUL  = 3'd4;
  localparam logic [PC_W-1:0] PC_DONE = 3'd5;

  typedef struct packed {
    logic [2:0]      op;
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      PC_GCD:  w = '{op: OP_GSTEP, cond: COND_LIVE, target: PC_GCD};
      PC_GFIN: w = '{op: OP_GFIN,  cond: COND_ZERO, target: PC_DONE};
      PC_DIV:  w = '{op: OP_DSTEP, cond: COND_CNT,  target: PC_DIV};
      PC_MINI: w = '{op: OP_MINIT, cond: COND_NEXT, target: PC_MUL};
      PC_MUL:  w = '{op: OP_MSTEP, cond: COND_CNT,  target: PC_MUL};
      PC_DONE: w = '{op: OP_DONE,  cond: COND_NEXT, target: PC_GCD};
      default: w = '{op: OP_DONE,  cond: COND_NEXT, target: PC_GCD};
    endcase
    return w;
  endfunction

endpackage

### src/gcd_lcm_unit.sv
// gcd_lcm_unit: gcd and exact lcm of two unsigned operands, microcoded sequencer
// depends on gcd_lcm_pkg (control word type, op codes, microcode rom)
//
//  channel  | ports                                              | handshake
//  ---------+----------------------------------------------------+------------------------
//  request  | in_operand_a, in_operand_b                         | start high, busy low
//  result   | out_gcd_value, out_lcm_value, out_zero_operand     | out_valid, one cycle
//
// a request runs a binary gcd loop of up to 2*DATA_WIDTH steps, then DATA_WIDTH restoring
//   divide steps for a/gcd and DATA_WIDTH shift-add multiply steps for (a/gcd)*b, all on
//   one datapath
// a zero operand skips divide and multiply
// reset: synchronous active low, clears the sequencer, busy and the strobe
// busy stays high from accept until the result strobe; the receiver cannot stall
module gcd_lcm_unit #(
  parameter int DATA_WIDTH = gcd_lcm_pkg::DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [DATA_WIDTH-1:0]   in_operand_a,
  input  logic [DATA_WIDTH-1:0]   in_operand_b,
  output logic                    out_valid,
  output logic [DATA_WIDTH-1:0]   out_gcd_value,
  output logic [2*DATA_WIDTH-1:0] out_lcm_value,
  output logic                    out_zero_operand
);

  localparam int W   = DATA_WIDTH;
  localparam int KW  = $clog2(W);
  localparam logic [KW-1:0] CNT_LAST = KW'(W - 1);

  // sequencer state
  logic                         busy_r, busy_nxt;
  logic [gcd_lcm_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // datapath registers
  logic [W-1:0]     x_r, x_nxt;       // gcd working value
  logic [W-1:0]     y_r, y_nxt;       // gcd working value
  logic [KW-1:0]    k_r, k_nxt;       // common power of two
  logic [W-1:0]     a_r, a_nxt;       // dividend, then quotient
  logic [W-1:0]     b_r, b_nxt;       // multiplicand
  logic [W-1:0]     g_r, g_nxt;       // gcd result
  logic [W-1:0]     rem_r, rem_nxt;   // divide remainder
  logic [2*W:0]     p_r, p_nxt;       // product, high part plus multiplier
  logic [KW-1:0]    cnt_r, cnt_nxt;
  logic             zero_r, zero_nxt;

  gcd_lcm_pkg::ctrl_word_t cw;

  logic         live;
  logic         cnt_more;
  logic         take_jump;
  logic [W:0]   rem_sh;
  logic [W:0]   rem_diff;
  logic [W:0]   psum;
  logic [W-1:0] x_sub_y;
  logic [W-1:0] y_sub_x;

  assign cw       = gcd_lcm_pkg::ucode_rom(pc_r);
  assign live     = (x_r != '0) && (y_r != '0);
  assign cnt_more = (cnt_r != CNT_LAST);
  assign x_sub_y  = x_r - y_r;
  assign y_sub_x  = y_r - x_r;
  assign rem_sh   = {rem_r, a_r[W-1]};
  assign rem_diff = rem_sh - {1'b0, g_r};
  assign psum     = {1'b0, p_r[2*W-1:W]} + {1'b0, b_r};

  always_comb begin
    case (cw.cond)
      gcd_lcm_pkg::COND_NEXT: take_jump = 1'b0;
      gcd_lcm_pkg::COND_LIVE: take_jump = live;
      gcd_lcm_pkg::COND_CNT:  take_jump = cnt_more;
      gcd_lcm_pkg::COND_ZERO: take_jump = zero_r;
      default:                take_jump = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    out_valid_nxt = 1'b0;
    x_nxt         = x_r;
    y_nxt         = y_r;
    k_nxt         = k_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    g_nxt         = g_r;
    rem_nxt       = rem_r;
    p_nxt         = p_r;
    cnt_nxt       = cnt_r;
    zero_nxt      = zero_r;

    if (!busy_r) begin
      if (start) begin
        // accept a request and start the program at the gcd loop
        busy_nxt = 1'b1;
        pc_nxt   = gcd_lcm_pkg::PC_GCD;
        x_nxt    = in_operand_a;
        y_nxt    = in_operand_b;
        a_nxt    = in_operand_a;
        b_nxt    = in_operand_b;
        k_nxt    = '0;
        zero_nxt = (in_operand_a == '0) || (in_operand_b == '0);
      end
    end else begin
      pc_nxt = take_jump ? cw.target : pc_r + 1'b1;
      case (cw.op)
        gcd_lcm_pkg::OP_GSTEP: begin
          // one binary gcd step, idle once either value reaches zero
          if (live) begin
            if (!x_r[0] && !y_r[0]) begin
              x_nxt = x_r >> 1;
              y_nxt = y_r >> 1;
              k_nxt = k_r + 1'b1;
            end else if (!x_r[0]) begin
              x_nxt = x_r >> 1;
            end else if (!y_r[0]) begin
              y_nxt = y_r >> 1;
            end else if (x_r >= y_r) begin
              x_nxt = x_sub_y >> 1;
            end else begin
              y_nxt = y_sub_x >> 1;
            end
          end
        end
        gcd_lcm_pkg::OP_GFIN: begin
          g_nxt   = (x_r | y_r) << k_r;
          rem_nxt = '0;
          cnt_nxt = '0;
        end
        gcd_lcm_pkg::OP_DSTEP: begin
          // restoring divide of a by gcd, quotient shifts into a_r
          if (!rem_diff[W]) begin
            rem_nxt = rem_diff[W-1:0];
            a_nxt   = {a_r[W-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh[W-1:0];
            a_nxt   = {a_r[W-2:0], 1'b0};
          end
          cnt_nxt = cnt_r + 1'b1;
        end
        gcd_lcm_pkg::OP_MINIT: begin
          p_nxt   = {{(W+1){1'b0}}, a_r};
          cnt_nxt = '0;
        end
        gcd_lcm_pkg::OP_MSTEP: begin
          // shift-add multiply, quotient in the low half
          if (p_r[0]) begin
            p_nxt = {1'b0, psum, p_r[W-1:1]};
          end else begin
            p_nxt = {1'b0, p_r[2*W:1]};
          end
          cnt_nxt = cnt_r + 1'b1;
        end
        gcd_lcm_pkg::OP_DONE: begin
          busy_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= gcd_lcm_pkg::PC_GCD;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    k_r    <= k_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    g_r    <= g_nxt;
    rem_r  <= rem_nxt;
    p_r    <= p_nxt;
    cnt_r  <= cnt_nxt;
    zero_r <= zero_nxt;
  end

  assign busy             = busy_r;
  assign out_valid        = out_valid_r;
  assign out_gcd_value    = g_r;
  assign out_lcm_value    = zero_r ? '0 : p_r[2*W-1:0];
  assign out_zero_operand = zero_r;

  // result strobe only follows the final step, which frees the unit
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // an accepted request always occupies the unit on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but unit not busy");

  // a zero operand always gives a zero lcm
  a_zero_lcm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_operand) |-> (out_lcm_value == '0))
    else $error("nonzero lcm with zero operand");

  // nonzero operands give a nonzero gcd
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_zero_operand) |-> (out_gcd_value != '0))
    else $error("zero gcd for nonzero operands");

  // the sequencer never leaves the program
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (pc_r <= gcd_lcm_pkg::PC_DONE))
    else $error("micro program counter out of range");

endmodule
